FILE: hw/rtl/rdc_pkg.sv
// ----------------------------------------------------------------------------
// rdc_pkg: recovery deploy controller package
// Shared widths, flag positions, register codes and status types.
// ----------------------------------------------------------------------------
`default_nettype none

package rdc_pkg;

  localparam int SET_SIZE_DEF = 32;
  localparam int SAMPLE_W     = 24;
  localparam int GROUND_W     = 29;
  localparam int HEIGHT_W     = 24;
  localparam int FLAGS_W      = 7;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 29;

  localparam logic [HEIGHT_W-1:0] DEPLOY_HEIGHT_RST = 24'd98937;

  // status flag bit positions
  localparam int FLG_LAUNCHED  = 0;
  localparam int FLG_ALLOWED   = 1;
  localparam int FLG_APOGEE    = 2;
  localparam int FLG_TIMER     = 3;
  localparam int FLG_STAGE1    = 4;
  localparam int FLG_THRESHOLD = 5;
  localparam int FLG_STAGE2    = 6;

  // flags that only reset clears
  localparam logic [FLAGS_W-1:0] STICKY_MASK = 7'b010_1111;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GROUND_SUM = 1'b0,
    CFG_DEPLOY_HGT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic closed;   // this sample closes a set
    logic rising;   // closed set sum above the previous one
  } accum_status_t;

endpackage : rdc_pkg

`default_nettype wire

FILE: hw/rtl/rdc_accum.sv
// ----------------------------------------------------------------------------
// rdc_accum: sample set accumulator
// Sums samples in sets, keeps the last closed set and flags a rising sum.
// ----------------------------------------------------------------------------
`default_nettype none

module rdc_accum
  import rdc_pkg::*;
#(
  parameter int SET_SIZE = SET_SIZE_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                accept,
  input  wire logic [SAMPLE_W-1:0] sample,
  output accum_status_t            status
);

  localparam int CNT_W = $clog2(SET_SIZE);
  localparam int SUM_W = SAMPLE_W + CNT_W;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SET_SIZE - 1);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [SUM_W-1:0] prev_r, prev_nxt;
  logic             have_prev_r, have_prev_nxt;
  logic [SUM_W-1:0] sum_add;

  assign sum_add       = sum_r + SUM_W'(sample);
  assign status.closed = (count_r == CNT_LAST);
  assign status.rising = have_prev_r && (sum_add > prev_r);

  always_comb begin
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    prev_nxt      = prev_r;
    have_prev_nxt = have_prev_r;
    if (accept) begin
      if (status.closed) begin
        count_nxt     = '0;
        sum_nxt       = '0;
        prev_nxt      = sum_add;
        have_prev_nxt = 1'b1;
      end else begin
        count_nxt = count_r + CNT_W'(1);
        sum_nxt   = sum_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      sum_r       <= '0;
      prev_r      <= '0;
      have_prev_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      prev_r      <= prev_nxt;
      have_prev_r <= have_prev_nxt;
    end
  end

endmodule : rdc_accum

`default_nettype wire

FILE: hw/rtl/rdc_flags.sv
// ----------------------------------------------------------------------------
// rdc_flags: flight flag logic
// Updates sticky event flags, apogee, threshold and stage enables per sample.
// ----------------------------------------------------------------------------
`default_nettype none

module rdc_flags
  import rdc_pkg::*;
#(
  parameter int SET_SIZE = SET_SIZE_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                accept,
  input  wire logic [SAMPLE_W-1:0] sample,
  input  wire logic                launch_event,
  input  wire logic                allow_event,
  input  wire logic                timer_event,
  input  wire logic [GROUND_W-1:0] ground_sum,
  input  wire logic [HEIGHT_W-1:0] deploy_height,
  input  accum_status_t            status,
  output logic [FLAGS_W-1:0]       flags_nxt,
  output logic [FLAGS_W-1:0]       flags_r
);

  localparam int MUL_W = $clog2(SET_SIZE + 1);
  localparam int ADD_W = SAMPLE_W + 1;
  localparam int BND_W = ADD_W + MUL_W;
  localparam int CMP_W = (BND_W > GROUND_W) ? BND_W : GROUND_W;

  logic [ADD_W-1:0]   height_add;
  logic [BND_W-1:0]   bound;
  logic               below;
  logic [FLAGS_W-1:0] f;

  assign height_add = ADD_W'(sample) + ADD_W'(deploy_height);
  assign bound      = BND_W'(height_add) * BND_W'(SET_SIZE);
  assign below      = CMP_W'(ground_sum) < CMP_W'(bound);

  always_comb begin
    f = flags_r;
    f[FLG_LAUNCHED] = f[FLG_LAUNCHED] | launch_event;
    f[FLG_ALLOWED]  = f[FLG_ALLOWED]  | allow_event;
    f[FLG_TIMER]    = f[FLG_TIMER]    | timer_event;
    if (status.closed && status.rising && f[FLG_ALLOWED]) begin
      f[FLG_APOGEE] = 1'b1;
    end
    f[FLG_STAGE1] = f[FLG_LAUNCHED] && f[FLG_ALLOWED] && (f[FLG_APOGEE] || f[FLG_TIMER]);
    if (status.closed && f[FLG_STAGE1] && below) begin
      f[FLG_THRESHOLD] = 1'b1;
    end
    f[FLG_STAGE2] = f[FLG_STAGE1] && f[FLG_THRESHOLD];
    flags_nxt = f;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else if (accept) begin
      flags_r <= flags_nxt;
    end
  end

endmodule : rdc_flags

`default_nettype wire

FILE: hw/rtl/rdc_out_reg.sv
// ----------------------------------------------------------------------------
// rdc_out_reg: result register
// Holds one result beat until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rdc_out_reg
  import rdc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               load,
  input  wire logic [FLAGS_W-1:0] flags,
  input  wire logic               closed,
  input  wire logic               out_tready,
  output logic                    out_tvalid,
  output logic [7:0]              out_tdata,
  output logic                    out_tlast,
  output logic                    free
);

  logic               valid_r, valid_nxt;
  logic [FLAGS_W-1:0] flags_r;
  logic               last_r;

  assign free      = !valid_r || out_tready;
  assign valid_nxt = load || (valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      flags_r <= flags;
      last_r  <= closed;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {1'b0, flags_r};
  assign out_tlast  = last_r;

endmodule : rdc_out_reg

`default_nettype wire

FILE: hw/rtl/recovery_deploy_controller_core.sv
// ----------------------------------------------------------------------------
// recovery_deploy_controller_core: recovery deploy controller
// Sums barometer samples in sets, tracks apogee and the deploy stage flags.
// ----------------------------------------------------------------------------
//
//  channel | dir | payload                                     | handshake
//  --------+-----+---------------------------------------------+-----------------
//  in_     | in  | tdata: pressure_raw; tuser: launch,allow,tmr | in_tvalid/tready
//  out_    | out | tdata: status_flags; tlast: set_complete     | out_tvalid/tready
//  cfg_    | in  | index + data, 0 ground sum, 1 deploy height  | cfg_valid/ready
//
//  One sample per cycle while the result register is free; the result beat
//  appears in the cycle after its sample beat is taken. The set logic is a
//  single add/compare and the threshold test an add, one constant multiply
//  and a compare, both between input and result. Synchronous active-low reset
//  clears counters, sums and all flags and loads the default deploy height.
//  A stalled result holds in the output register; a new sample is taken in
//  the same cycle the held beat leaves. Configuration writes are always taken.
// ----------------------------------------------------------------------------
`default_nettype none

module recovery_deploy_controller_core
  import rdc_pkg::*;
#(
  parameter int SET_SIZE = SET_SIZE_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // in_tdata[23:0] pressure_raw
  input  wire logic [SAMPLE_W-1:0]   in_tdata,
  // in_tuser[0] launch_event, [1] allow_event, [2] timer_event
  input  wire logic [2:0]            in_tuser,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // out_tdata[6:0] status_flags, [7] zero
  output logic [7:0]                 out_tdata,
  output logic                       out_tlast,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic                accept;
  logic                free;
  accum_status_t       status;
  logic [FLAGS_W-1:0]  flags_nxt;
  logic [FLAGS_W-1:0]  flags_r;
  logic [GROUND_W-1:0] ground_sum_r;
  logic [HEIGHT_W-1:0] deploy_height_r;

  // Take a sample whenever the result register is empty or draining.
  assign in_tready = free;
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Configuration registers: decode the index and load the selected register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ground_sum_r    <= '0;
      deploy_height_r <= DEPLOY_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_GROUND_SUM: ground_sum_r    <= cfg_data[GROUND_W-1:0];
        CFG_DEPLOY_HGT: deploy_height_r <= cfg_data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Set accumulator: sample count, running and previous sums.
  rdc_accum #(
    .SET_SIZE (SET_SIZE)
  ) u_accum (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .sample (in_tdata),
    .status (status)
  );

  // Flag logic: sticky events, apogee, stage one, threshold, stage two.
  rdc_flags #(
    .SET_SIZE (SET_SIZE)
  ) u_flags (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .sample        (in_tdata),
    .launch_event  (in_tuser[0]),
    .allow_event   (in_tuser[1]),
    .timer_event   (in_tuser[2]),
    .ground_sum    (ground_sum_r),
    .deploy_height (deploy_height_r),
    .status        (status),
    .flags_nxt     (flags_nxt),
    .flags_r       (flags_r)
  );

  // Result register: holds the beat across downstream stalls.
  rdc_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .flags      (flags_nxt),
    .closed     (status.closed),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .free       (free)
  );

  // Sticky flags never drop once set.
  a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> ((flags_r & $past(flags_r) & STICKY_MASK) == ($past(flags_r) & STICKY_MASK)))
    else $error("sticky flag cleared");

  // Stage two never shows without stage one.
  a_stage2: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tdata[FLG_STAGE2] || out_tdata[FLG_STAGE1]))
    else $error("stage two without stage one");

  // Stage one needs launched and allowed.
  a_stage1: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tdata[FLG_STAGE1] ||
                    (out_tdata[FLG_LAUNCHED] && out_tdata[FLG_ALLOWED])))
    else $error("stage one without launch and allow");

  // No sample is taken while a held result is stalled.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !accept)
    else $error("sample taken over a stalled result");

  // The shown flags are the registered flag state.
  a_flags_match: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (out_tdata[FLAGS_W-1:0] == flags_r))
    else $error("result flags differ from flag state");

endmodule : recovery_deploy_controller_core

`default_nettype wire
